// ===== hdl/rrf_pkg.sv =====
`default_nettype none

package rrf_pkg;

    localparam int unsigned IDX_W    = 5;
    localparam int unsigned NUM_REGS = 2 ** IDX_W;
    localparam int unsigned TAG_W    = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MODE_W   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_RENAME = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_COMMIT = 3'd4
    } t_mode;

    // one operation handed to the register state; valid marks the cycle it takes effect
    typedef struct packed {
        logic                     valid;
        t_mode                    mode;
        logic [IDX_W-1:0]         idx;
        logic [TAG_W-1:0]         tag;
        logic signed [DATA_W-1:0] value;
    } t_op;

    typedef struct packed {
        logic                     busy;
        logic signed [DATA_W-1:0] value;
    } t_rd;

endpackage

`default_nettype wire

// ===== hdl/rrf_in_if.sv =====
`default_nettype none

interface rrf_in_if;
    import rrf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         reg_addr;
    logic [TAG_W-1:0]         rob_tag;
    logic signed [DATA_W-1:0] write_value;

    modport source (output valid, output mode, output reg_addr, output rob_tag,
                    output write_value, input ready);
    modport sink   (input valid, input mode, input reg_addr, input rob_tag,
                    input write_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrf_out_if.sv =====
`default_nettype none

interface rrf_out_if;
    import rrf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     reg_busy;
    logic signed [DATA_W-1:0] reg_value;

    modport source (output valid, output reg_busy, output reg_value, input ready);
    modport sink   (input valid, input reg_busy, input reg_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrf_state.sv =====
`default_nettype none

module rrf_state (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire rrf_pkg::t_op i_op,
    output rrf_pkg::t_rd      o_rd
);
    import rrf_pkg::*;

    logic signed [DATA_W-1:0] r_cur_value [NUM_REGS];
    logic [NUM_REGS-1:0]      r_cur_busy;
    logic signed [DATA_W-1:0] r_pnd_value [NUM_REGS];
    logic [NUM_REGS-1:0]      r_pnd_busy;
    logic [TAG_W-1:0]         r_pnd_tag [NUM_REGS];

    logic signed [DATA_W-1:0] n_cur_value [NUM_REGS];
    logic [NUM_REGS-1:0]      n_cur_busy;
    logic signed [DATA_W-1:0] n_pnd_value [NUM_REGS];
    logic [NUM_REGS-1:0]      n_pnd_busy;
    logic [TAG_W-1:0]         n_pnd_tag [NUM_REGS];

    // current tags are never read back, so only the pending copy keeps them
    always_comb begin
        n_cur_value = r_cur_value;
        n_cur_busy  = r_cur_busy;
        n_pnd_value = r_pnd_value;
        n_pnd_busy  = r_pnd_busy;
        n_pnd_tag   = r_pnd_tag;
        if (i_op.valid) begin
            unique case (i_op.mode)
                MODE_READ: begin
                end
                MODE_WRITE: begin
                    n_pnd_value[i_op.idx] = i_op.value;
                    if (r_pnd_busy[i_op.idx] && (r_pnd_tag[i_op.idx] == i_op.tag)) begin
                        n_pnd_busy[i_op.idx] = 1'b0;
                    end
                end
                MODE_RENAME: begin
                    n_pnd_busy[i_op.idx] = 1'b1;
                    n_pnd_tag[i_op.idx]  = i_op.tag;
                end
                MODE_CLEAR: begin
                    n_pnd_busy = '0;
                end
                MODE_COMMIT: begin
                    n_cur_value = r_pnd_value;
                    n_cur_busy  = r_pnd_busy;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_busy <= '0;
            r_pnd_busy <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cur_value[i] <= '0;
                r_pnd_value[i] <= '0;
                r_pnd_tag[i]   <= '0;
            end
        end else begin
            r_cur_value <= n_cur_value;
            r_cur_busy  <= n_cur_busy;
            r_pnd_value <= n_pnd_value;
            r_pnd_busy  <= n_pnd_busy;
            r_pnd_tag   <= n_pnd_tag;
        end
    end

    // busy registers read as all ones
    always_comb begin
        o_rd.busy  = r_cur_busy[i_op.idx];
        o_rd.value = r_cur_busy[i_op.idx] ? '1 : r_cur_value[i_op.idx];
    end

endmodule

`default_nettype wire

// ===== hdl/renamed_register_file.sv =====
// Renamed register file: 32 architectural registers, each with a current and a
// pending copy of value and busy bit; only the pending copy keeps a reorder-buffer tag.
// i_in carries one operation per word: read, write result, rename, clear all
// dependencies or commit pending. Only a read gives a word on o_out (busy bit,
// and the current value or all ones when busy); other operations give nothing.
// A read passes the input register, then the output register that drives o_out.
// i_in takes one word per cycle unless a stalled read holds the input register;
// each operation is a single indexed update or a whole-array copy in the flip-flop state.
// Operations take effect strictly in arrival order.
// Reset clears every value, tag and busy bit in both copies; o_out goes empty.
// When o_out stalls, the read result waits in the output register; non-read
// operations still pass through, and a following read holds in the input
// register, which then drops i_in.ready until the result is taken.
`default_nettype none

module renamed_register_file (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrf_in_if.sink    i_in,
    rrf_out_if.source o_out
);
    import rrf_pkg::*;

    logic                     r_s_valid;
    t_op                      r_s;
    logic                     r_out_valid;
    logic                     r_out_busy;
    logic signed [DATA_W-1:0] r_out_value;

    logic s_is_read;
    logic s_go;
    t_op  op;
    t_rd  rd;

    assign s_is_read = (r_s.mode == MODE_READ);
    // a read only moves on when the output register has room
    assign s_go      = r_s_valid && (!s_is_read || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s_valid || s_go;

    always_comb begin
        op       = r_s;
        op.valid = s_go;
    end

    rrf_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .o_rd    (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s_valid <= 1'b1;
        end else if (s_go) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s.valid <= 1'b1;
            r_s.mode  <= t_mode'(i_in.mode);
            r_s.idx   <= i_in.reg_addr;
            r_s.tag   <= i_in.rob_tag;
            r_s.value <= i_in.write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && s_is_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && s_is_read) begin
            r_out_busy  <= rd.busy;
            r_out_value <= rd.value;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.reg_busy  = r_out_busy;
    assign o_out.reg_value = r_out_value;

    a_busy_reads_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && s_is_read && rd.busy) |=> (o_out.valid && o_out.reg_value == '1))
        else $error("busy register did not read as all ones");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !s_go) |=> (r_s_valid && $stable(r_s)))
        else $error("held operation lost or changed");

    a_stalled_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && s_is_read && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a read was stalled");

    a_result_only_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(s_go && s_is_read)) |=> !o_out.valid)
        else $error("result word without a read");

endmodule

`default_nettype wire
